// ===== rtl/ttip_pkg.sv =====
`timescale 1ns / 1ps
package ttip_pkg;

    localparam int BaseW      = 5;
    localparam int ValueW     = 64;
    localparam int CountW     = 12;
    localparam int QueueDepth = 2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       start_req;
    } t_in_item;

    typedef struct packed {
        logic signed [ValueW-1:0] value;
        logic [CountW-1:0]        chars_consumed;
    } t_out_item;

    // classified character, as handed from front to back
    typedef struct packed {
        logic             start;
        logic [BaseW-1:0] base;
        logic             is_space;
        logic             is_plus;
        logic             is_minus;
        logic             is_zero;
        logic             is_x;
        logic             dig_ok;
        logic [3:0]       dig;
    } t_cls;

endpackage

// ===== rtl/text_to_integer_parser.sv =====
`timescale 1ns / 1ps
// Path: a character transfer is written into the queue, then taken into the back end's
//   state; a result caused by it is registered and presented on o_out_valid.
// Throughput: one character per cycle without output stalls, set by the single 64x5
//   multiply-add in the back end; a two-entry queue lets input and output stall independently.
// Reset (synchronous, active low): queue emptied, no result pending, parser idle and
//   ignoring characters until a start, number_base back to 10.
module text_to_integer_parser
    import ttip_pkg::*;
#(
    parameter int MAX_TEXT_LEN = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic [BaseW-1:0] i_cfg_wdata
);

    logic [BaseW-1:0] r_number_base;
    logic             cls_valid, q_full_n, q_valid, q_pop;
    t_cls             cls, q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BaseW'(10);
        end else if (i_cfg_we) begin
            r_number_base <= i_cfg_wdata;
        end
    end

    ttip_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_number_base (r_number_base),
        .o_cls_valid   (cls_valid),
        .i_cls_ready   (q_full_n),
        .o_cls         (cls)
    );

    ttip_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (cls_valid),
        .o_full_n (q_full_n),
        .i_wdata  (cls),
        .o_valid  (q_valid),
        .i_pop    (q_pop),
        .o_rdata  (q_data)
    );

    ttip_back #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (q_valid),
        .o_cls_pop   (q_pop),
        .i_cls       (q_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/ttip_front.sv =====
`timescale 1ns / 1ps
module ttip_front
    import ttip_pkg::*;
(
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    input  logic [BaseW-1:0] i_number_base,
    output logic             o_cls_valid,
    input  logic             i_cls_ready,
    output t_cls             o_cls
);

    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChNl    = 8'h0A;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChLowX  = 8'h78;
    localparam logic [7:0] ChUpX   = 8'h58;

    logic [7:0] c;
    logic       dig_ok;
    logic [3:0] dig;
    logic [7:0] dig_wide;

    assign c = i_in_data.char_code;

    always_comb begin
        dig_ok   = 1'b1;
        dig_wide = 8'd0;
        case (c) inside
            [8'h30:8'h39]: dig_wide = c - 8'h30;
            [8'h61:8'h66]: dig_wide = c - 8'h57;
            [8'h41:8'h46]: dig_wide = c - 8'h37;
            default:       dig_ok   = 1'b0;
        endcase
        dig = dig_wide[3:0];
    end

    assign o_cls_valid    = i_in_valid;
    assign o_in_ready     = i_cls_ready;
    assign o_cls.start    = i_in_data.start_req;
    assign o_cls.base     = i_number_base;
    assign o_cls.is_space = c inside {ChSpace, ChTab, ChNl};
    assign o_cls.is_plus  = (c == ChPlus);
    assign o_cls.is_minus = (c == ChMinus);
    assign o_cls.is_zero  = (c == ChZero);
    assign o_cls.is_x     = c inside {ChLowX, ChUpX};
    assign o_cls.dig_ok   = dig_ok;
    assign o_cls.dig      = dig;

endmodule

// ===== rtl/ttip_queue.sv =====
`timescale 1ns / 1ps
module ttip_queue
    import ttip_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full_n,
    input  t_cls i_wdata,
    output logic o_valid,
    input  logic i_pop,
    output t_cls o_rdata
);

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    t_cls            r_mem [QueueDepth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            push_ok, pop_ok;

    assign o_full_n = (r_cnt != CntW'(QueueDepth));
    assign o_valid  = (r_cnt != '0);
    assign o_rdata  = r_mem[r_rd_ptr];
    assign push_ok  = i_push && o_full_n;
    assign pop_ok   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// ===== rtl/ttip_back.sv =====
`timescale 1ns / 1ps
module ttip_back
    import ttip_pkg::*;
#(
    parameter int MAX_TEXT_LEN = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cls_valid,
    output logic      o_cls_pop,
    input  t_cls      i_cls,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam logic [2:0] PhDone  = 3'd0;
    localparam logic [2:0] PhSpace = 3'd1;
    localparam logic [2:0] PhPref  = 3'd2;
    localparam logic [2:0] PhZeroX = 3'd3;
    localparam logic [2:0] PhDigit = 3'd4;

    localparam int CountCapInt = (MAX_TEXT_LEN - 1 < 4095) ? MAX_TEXT_LEN - 1 : 4095;
    localparam logic [CountW-1:0] CountCap = CountW'(CountCapInt);

    localparam logic [BaseW-1:0] Base8  = BaseW'(8);
    localparam logic [BaseW-1:0] Base10 = BaseW'(10);
    localparam logic [BaseW-1:0] Base16 = BaseW'(16);

    logic [2:0]              r_phase, n_phase;
    logic                    r_neg, n_neg;
    logic [ValueW-1:0]       r_acc, n_acc;
    logic [BaseW-1:0]        r_base, n_base;
    logic [CountW-1:0]       r_cnt, n_cnt;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    logic                    go, take, mac, emit;
    logic [ValueW+BaseW-1:0] prod;

    assign o_cls_pop = i_cls_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_base  = r_base;
        n_cnt   = r_cnt;
        go      = 1'b0;
        take    = 1'b0;
        mac     = 1'b0;
        emit    = 1'b0;
        if (o_cls_pop) begin
            if (i_cls.start) begin
                n_phase = PhSpace;
                n_neg   = 1'b0;
                n_acc   = '0;
                n_base  = i_cls.base;
                n_cnt   = '0;
            end
            go = (n_phase != PhDone);
            if (go && n_phase == PhSpace) begin
                if (i_cls.is_space) begin
                    take = 1'b1;
                    go   = 1'b0;
                end else begin
                    n_phase = PhPref;
                    if (i_cls.is_plus || i_cls.is_minus) begin
                        n_neg = i_cls.is_minus;
                        take  = 1'b1;
                        go    = 1'b0;
                    end
                end
            end
            if (go && n_phase == PhPref) begin
                if ((n_base == '0 || n_base == Base16) && i_cls.is_zero) begin
                    take    = 1'b1;
                    n_phase = PhZeroX;
                    go      = 1'b0;
                end else begin
                    if (n_base == '0) begin
                        n_base = Base10;
                    end
                    n_phase = PhDigit;
                end
            end else if (go && n_phase == PhZeroX) begin
                if (i_cls.is_x) begin
                    n_base  = Base16;
                    take    = 1'b1;
                    n_phase = PhDigit;
                    go      = 1'b0;
                end else begin
                    if (n_base == '0) begin
                        n_base = Base8;
                    end
                    n_phase = PhDigit;
                end
            end
            if (go) begin
                if (i_cls.dig_ok && {1'b0, i_cls.dig} < n_base) begin
                    mac  = 1'b1;
                    take = 1'b1;
                end else begin
                    emit    = 1'b1;
                    n_phase = PhDone;
                end
            end
        end
        prod = n_acc * n_base;
        if (mac) begin
            n_acc = prod[ValueW-1:0] + ValueW'(i_cls.dig);
        end
        if (take && n_cnt < CountCap) begin
            n_cnt = n_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PhDone;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_base      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_base  <= n_base;
            r_cnt   <= n_cnt;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data.value          <= n_neg ? -n_acc : n_acc;
            r_out_data.chars_consumed <= n_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/ttip_checker.sv =====
`timescale 1ns / 1ps
module ttip_checker
    import ttip_pkg::*;
#(
    parameter int MAX_TEXT_LEN = 4096
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input t_out_item        o_out_data
);

    localparam int CountCapInt = (MAX_TEXT_LEN - 1 < 4095) ? MAX_TEXT_LEN - 1 : 4095;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result transfer changed");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.chars_consumed == '0 |-> o_out_data.value == '0)
        else $error("nonzero value with nothing consumed");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.chars_consumed <= CountW'(CountCapInt))
        else $error("consumed count beyond cap");

endmodule

bind text_to_integer_parser ttip_checker #(.MAX_TEXT_LEN(MAX_TEXT_LEN)) u_ttip_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import ttip_pkg::*;

    localparam int TEXT_LEN     = 4096;
    localparam int COUNT_CAP    = (TEXT_LEN - 1 < 4095) ? TEXT_LEN - 1 : 4095;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int WRAP_DIGITS  = 40;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_HIGH    = 8'hFF;
    localparam int unsigned NOT_DIGIT = 255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLANKS,
        ST_SIGNED,
        ST_ZERO,
        ST_DIGITS
    } scan_state_e;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_in_item         i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_item        o_out_data;
    logic             i_cfg_we    = 1'b0;
    logic [BaseW-1:0] i_cfg_wdata = '0;

    // predictor state
    logic [BaseW-1:0]  cfg_base = 5'd10;
    scan_state_e       scan_st  = ST_IDLE;
    logic              is_neg   = 1'b0;
    logic [ValueW-1:0] acc      = '0;
    logic [BaseW-1:0]  run_base = '0;
    logic [CountW-1:0] taken_n  = '0;

    t_out_item   parsed_q[$];
    int unsigned err_count   = 0;
    int unsigned live_items  = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    bit          fresh       = 1'b1;

    text_to_integer_parser #(
        .MAX_TEXT_LEN(TEXT_LEN)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic int unsigned hex_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return 32'(c - CH_ZERO);
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) return 32'(c - CH_LOWER_A) + 10;
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) return 32'(c - CH_UPPER_A) + 10;
        return NOT_DIGIT;
    endfunction

    task automatic count_char();
        if (taken_n < COUNT_CAP) taken_n++;
    endtask

    task automatic predict_char(input t_in_item it);
        logic [7:0] c;
        int unsigned d;
        t_out_item r;
        c = it.char_code;
        if (it.start_req) begin
            scan_st  = ST_BLANKS;
            is_neg   = 1'b0;
            acc      = '0;
            run_base = cfg_base;
            taken_n  = '0;
        end
        if (scan_st == ST_IDLE) return;
        if (scan_st == ST_BLANKS) begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
                count_char();
                return;
            end
            scan_st = ST_SIGNED;
            if (c == CH_MINUS || c == CH_PLUS) begin
                is_neg = (c == CH_MINUS);
                count_char();
                return;
            end
        end
        if (scan_st == ST_SIGNED) begin
            if ((run_base == 0 || run_base == 16) && c == CH_ZERO) begin
                count_char();
                scan_st = ST_ZERO;
                return;
            end
            if (run_base == 0) run_base = 5'd10;
            scan_st = ST_DIGITS;
        end else if (scan_st == ST_ZERO) begin
            if (c == CH_LOWER_X || c == CH_UPPER_X) begin
                run_base = 5'd16;
                count_char();
                scan_st = ST_DIGITS;
                return;
            end
            if (run_base == 0) run_base = 5'd8;
            scan_st = ST_DIGITS;
        end
        d = hex_digit(c);
        if (d < run_base) begin
            acc = acc * 64'(run_base) + 64'(d);
            count_char();
            return;
        end
        scan_st = ST_IDLE;
        r.value = is_neg ? (64'd0 - acc) : acc;
        r.chars_consumed = taken_n;
        parsed_q.push_back(r);
    endtask

    // one character transfer; called at a rising edge
    task automatic send_char(input logic [7:0] code, input logic first);
        t_in_item item;
        int unsigned gap;
        bit accepted;
        item.char_code = code;
        item.start_req = first;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do begin
            @(negedge i_clk);
            accepted = o_in_ready;
            @(posedge i_clk);
        end while (!accepted);
        if (first || scan_st != ST_IDLE) live_items++;
        predict_char(item);
    endtask

    task automatic put_char(input logic [7:0] c);
        send_char(c, fresh);
        fresh = 1'b0;
    endtask

    task automatic start_text(input string s);
        fresh = 1'b1;
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (parsed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [BaseW-1:0] b);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= b;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_base = b;
    endtask

    function automatic logic [7:0] digit_char(input int unsigned d);
        if (d < 10) return 8'(CH_ZERO + d);
        return 8'(($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + d - 10);
    endfunction

    function automatic logic [7:0] x_char();
        return $urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X;
    endfunction

    always @(negedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (parsed_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%0d count=%0d",
                                          o_out_data.value, o_out_data.chars_consumed));
            end else begin
                want = parsed_q.pop_front();
                if (o_out_data.value !== want.value)
                    report_mismatch($sformatf("value %0d, want %0d",
                                              o_out_data.value, want.value));
                if (o_out_data.chars_consumed !== want.chars_consumed)
                    report_mismatch($sformatf("chars_consumed %0d, want %0d",
                                              o_out_data.chars_consumed,
                                              want.chars_consumed));
            end
        end
    end

    // base left at its reset value of 10
    task automatic test_blanks_and_restart();
        send_char(CH_UPPER_A, 1'b0);
        send_char(CH_HIGH, 1'b0);
        start_text(" \t\n-987");
        put_char(CH_NUL);
        send_char(CH_LOWER_X, 1'b0);
        start_text("+4");
        start_text("5,");
        send_char(CH_NUL, 1'b1);
        send_char(CH_HIGH, 1'b1);
        settle();
    endtask

    task automatic test_base_detect();
        write_base(5'd0);
        start_text("0x1F");
        put_char(CH_NUL);
        start_text("0Xg");
        start_text("017");
        put_char(CH_NUL);
        start_text("-0");
        put_char(CH_NUL);
        start_text("90a");
        settle();
    endtask

    task automatic test_hex_prefix();
        write_base(5'd16);
        start_text("0xfF ");
        start_text("+Ab,");
        start_text("0x.");
        settle();
    endtask

    task automatic test_odd_radix();
        write_base(5'd1);
        start_text("010");
        settle();
        write_base(5'd31);
        start_text("fF");
        put_char(CH_NUL);
        settle();
    endtask

    // wraps the accumulator
    task automatic test_wrap_and_saturation();
        write_base(5'd16);
        start_text("-");
        repeat (WRAP_DIGITS) put_char(digit_char($urandom_range(0, 15)));
        put_char(CH_NUL);
        settle();
    endtask

    task automatic send_number();
        int unsigned kind;
        int unsigned eff;
        int unsigned dmax;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 8))
                send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            return;
        end
        fresh = 1'b1;
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 2))
                0: put_char(CH_SPACE);
                1: put_char(CH_TAB);
                default: put_char(CH_NL);
            endcase
        end
        case ($urandom_range(0, 2))
            0: put_char(CH_MINUS);
            1: put_char(CH_PLUS);
            default: ;
        endcase
        eff = 32'(cfg_base);
        if (cfg_base == 0) begin
            case ($urandom_range(0, 2))
                0: begin
                    put_char(CH_ZERO);
                    put_char(x_char());
                    eff = 16;
                end
                1: begin
                    put_char(CH_ZERO);
                    eff = 8;
                end
                default: begin
                    eff = 10;
                    put_char(digit_char($urandom_range(1, 9)));
                end
            endcase
        end else if (cfg_base == 16 && $urandom_range(0, 1)) begin
            put_char(CH_ZERO);
            put_char(x_char());
        end
        dmax = (eff > 16) ? 16 : eff;
        repeat ($urandom_range(0, 22)) put_char(digit_char($urandom_range(0, dmax - 1)));
        if (kind == 1) return;  // cut short by the next start
        case ($urandom_range(0, 3))
            0: put_char(CH_NUL);
            1: put_char(CH_SPACE);
            2: put_char(CH_COMMA);
            default: put_char(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0);
    endtask

    function automatic logic [BaseW-1:0] pick_base();
        case ($urandom_range(0, 9))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return 5'd31;
            4: return 5'd10;
            5: return 5'd8;
            6: return 5'd2;
            7: return 5'd17;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    task automatic test_random();
        int unsigned goal;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            goal = live_items + RANDOM_ITEMS / 4;
            while (live_items < goal) begin
                settle();
                write_base(pick_base());
                repeat ($urandom_range(2, 6)) send_number();
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
        settle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_blanks_and_restart();
        test_base_detect();
        test_hex_prefix();
        test_odd_radix();
        test_wrap_and_saturation();
        live_items = 0;
        test_random();
        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
